[rtl/core/mwlfo_pkg.sv]
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared widths, codes, configuration type and sine table function for the
// multi-waveform LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mwlfo_pkg;

	localparam int LEVEL_W   = 8;
	localparam int WAVE_W    = 3;
	localparam int PERIOD_W  = 32;
	localparam int DATA_W    = 32;
	localparam int REG_COUNT = 4;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int ADDR_W    = $clog2(REG_COUNT * 4);
	localparam int LEVEL_TOP = (1 << LEVEL_W) - 1;

	localparam int SINE_STEPS_DEF     = 314;
	localparam int SINE_FRAC_BITS_DEF = 16;

	localparam logic [WAVE_W-1:0]   WAVEFORM_RST  = '0;
	localparam logic [LEVEL_W-1:0]  LEVEL_MIN_RST = '0;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 32'd2000000;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_PI      = 64'd3373259426;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint unsigned Q30_TWO_PI  = 64'd6746518852;
	localparam longint unsigned RAD_DIV     = 64'd50;

	typedef enum logic [WAVE_W-1:0] {
		WAVE_SINE       = 3'd0,
		WAVE_TRIANGLE   = 3'd1,
		WAVE_RAMP_UP    = 3'd2,
		WAVE_RAMP_DOWN  = 3'd3,
		WAVE_SQUARE     = 3'd4
	} wave_t;

	typedef enum logic [IDX_W-1:0] {
		REG_WAVEFORM  = 2'd0,
		REG_LEVEL_MIN = 2'd1,
		REG_LEVEL_MAX = 2'd2,
		REG_PERIOD    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WAVE_W-1:0]   waveform;
		logic [LEVEL_W-1:0]  level_min;
		logic [LEVEL_W-1:0]  level_max;
		logic [PERIOD_W-1:0] period_us;
	} cfg_t;

	// Evaluated at elaboration only, to build the sine table contents.
	function automatic logic [31:0] sine_frac_of(input int unsigned i,
		input int unsigned frac_bits);
		longint unsigned a;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned s;
		longint unsigned v;
		longint unsigned f;
		longint unsigned fmax;
		logic negative;
		a = ((longint'(i) << 30) + RAD_DIV / 2) / RAD_DIV;
		negative = 1'b0;
		a = a % Q30_TWO_PI;
		if (a >= Q30_PI) begin
			a = a - Q30_PI;
			negative = 1'b1;
		end
		if (a > Q30_HALF_PI) a = Q30_PI - a;
		x2 = (a * a) >> 30;
		term = a;
		pos = a;
		neg = 0;
		for (int n = 1; n <= 7; n++) begin
			term = (term * x2) >> 30;
			case (n)
				1:       term = term / 64'd6;
				2:       term = term / 64'd20;
				3:       term = term / 64'd42;
				4:       term = term / 64'd72;
				5:       term = term / 64'd110;
				6:       term = term / 64'd156;
				default: term = term / 64'd210;
			endcase
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		s = (pos > neg) ? pos - neg : 0;
		if (s > Q30_ONE) s = Q30_ONE;
		v = negative ? (Q30_ONE / 2) - s / 2 : (Q30_ONE / 2) + s / 2;
		f = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
		fmax = (64'd1 << frac_bits) - 1;
		return (f > fmax) ? fmax[31:0] : f[31:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/mwlfo_tick_if.sv]
// ----------------------------------------------------------------------------
// mwlfo_tick_if
// Valid/ready channel carrying one microsecond tick per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwlfo_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

`default_nettype wire

[rtl/core/mwlfo_level_if.sv]
// ----------------------------------------------------------------------------
// mwlfo_level_if
// Valid/ready channel carrying the LFO level and phase-restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwlfo_level_if;
	logic       valid;
	logic       ready;
	logic [7:0] level;
	logic       phase_restart;

	modport source (output valid, output level, output phase_restart, input ready);
	modport sink (input valid, input level, input phase_restart, output ready);
endinterface

`default_nettype wire

[rtl/core/mwlfo_regs.sv]
// ----------------------------------------------------------------------------
// mwlfo_regs
// APB register file for waveform, level limits and period. Every write
// requests a new step interval computation.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mwlfo_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mwlfo_pkg::DATA_W-1:0]  pwdata,
	output logic      [mwlfo_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	output mwlfo_pkg::cfg_t                    cfg,
	output logic                               start
);
	import mwlfo_pkg::*;

	cfg_t     cfg_q;
	logic     start_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waveform  <= WAVEFORM_RST;
			cfg_q.level_min <= LEVEL_MIN_RST;
			cfg_q.level_max <= LEVEL_MAX_RST;
			cfg_q.period_us <= PERIOD_RST;
			start_q         <= 1'b1;
		end else begin
			start_q <= wr_en;
			if (wr_en) begin
				unique case (idx)
					REG_WAVEFORM:  cfg_q.waveform  <= pwdata[WAVE_W-1:0];
					REG_LEVEL_MIN: cfg_q.level_min <= pwdata[LEVEL_W-1:0];
					REG_LEVEL_MAX: cfg_q.level_max <= pwdata[LEVEL_W-1:0];
					REG_PERIOD:    cfg_q.period_us <= pwdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_WAVEFORM:  prdata = DATA_W'(cfg_q.waveform);
			REG_LEVEL_MIN: prdata = DATA_W'(cfg_q.level_min);
			REG_LEVEL_MAX: prdata = DATA_W'(cfg_q.level_max);
			REG_PERIOD:    prdata = DATA_W'(cfg_q.period_us);
			default:       prdata = '0;
		endcase
	end

	assign cfg   = cfg_q;
	assign start = start_q;

endmodule

`default_nettype wire

[rtl/core/mwlfo_div.sv]
// ----------------------------------------------------------------------------
// mwlfo_div
// Bit-serial restoring divider that derives the step interval from the
// period and the selected waveform, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_div #(
	parameter int SINE_STEPS = mwlfo_pkg::SINE_STEPS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire mwlfo_pkg::cfg_t                 cfg,
	output logic      [mwlfo_pkg::PERIOD_W-1:0]  interval,
	output logic                                 busy
);
	import mwlfo_pkg::*;

	localparam int DIV_MAX = (SINE_STEPS > 2 * LEVEL_TOP) ? SINE_STEPS : 2 * LEVEL_TOP;
	localparam int DIV_W   = $clog2(DIV_MAX + 1);
	localparam int CNT_W   = $clog2(PERIOD_W);

	logic                run_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    dsr_q;
	logic [PERIOD_W-1:0] quo_q;
	logic                dbl_q;
	logic [PERIOD_W-1:0] interval_q;

	logic [LEVEL_W-1:0]  hi;
	logic [LEVEL_W-1:0]  rng;
	logic [LEVEL_W-1:0]  rg;
	logic [DIV_W-1:0]    dsr_d;
	logic [DIV_W:0]      trial;
	logic                qbit;
	logic [DIV_W-1:0]    rem_d;
	logic [PERIOD_W-1:0] quo_d;
	logic                last;

	always_comb begin
		hi  = (cfg.level_max < cfg.level_min) ? cfg.level_min : cfg.level_max;
		rng = hi - cfg.level_min;
		rg  = (rng == '0) ? LEVEL_W'(1) : rng;
		case (wave_t'(cfg.waveform))
			WAVE_SINE:      dsr_d = DIV_W'(SINE_STEPS);
			WAVE_TRIANGLE:  dsr_d = DIV_W'({rg, 1'b0});
			WAVE_RAMP_UP,
			WAVE_RAMP_DOWN: dsr_d = DIV_W'(rg);
			default:        dsr_d = DIV_W'(1);
		endcase
	end

	always_comb begin
		trial = {rem_q, quo_q[PERIOD_W-1]};
		qbit  = (trial >= {1'b0, dsr_q});
		rem_d = qbit ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
		quo_d = {quo_q[PERIOD_W-2:0], qbit};
		last  = (cnt_q == CNT_W'(PERIOD_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			cnt_q      <= '0;
			interval_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				run_q <= 1'b0;
				cnt_q <= '0;
				if (dbl_q) begin
					interval_q <= quo_d[PERIOD_W-1] ? '1 : {quo_d[PERIOD_W-2:0], 1'b0};
				end else begin
					interval_q <= quo_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= cfg.period_us;
			dsr_q <= dsr_d;
			dbl_q <= (wave_t'(cfg.waveform) == WAVE_RAMP_UP) ||
			         (wave_t'(cfg.waveform) == WAVE_RAMP_DOWN);
		end else if (run_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign interval = interval_q;
	assign busy     = start || run_q;

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> run_q)
		else $error("divider did not start after a request");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (cnt_q == '0))
		else $error("divider count not cleared while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && last && !start) |=> !run_q)
		else $error("divider kept running past the last quotient bit");

endmodule

`default_nettype wire

[rtl/core/mwlfo_sine_rom.sv]
// ----------------------------------------------------------------------------
// mwlfo_sine_rom
// Sine table holding (sin + 1) / 2 as an unsigned fraction, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_sine_rom #(
	parameter int SINE_STEPS     = mwlfo_pkg::SINE_STEPS_DEF,
	parameter int SINE_FRAC_BITS = mwlfo_pkg::SINE_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic [$clog2(SINE_STEPS)-1:0]     addr,
	output logic      [SINE_FRAC_BITS-1:0]         data
);
	import mwlfo_pkg::*;

	logic [SINE_FRAC_BITS-1:0] rom [SINE_STEPS];
	logic [SINE_FRAC_BITS-1:0] data_q;

	for (genvar g = 0; g < SINE_STEPS; g++) begin : g_rom
		assign rom[g] = SINE_FRAC_BITS'(sine_frac_of(g, SINE_FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

[rtl/core/mwlfo_core.sv]
// ----------------------------------------------------------------------------
// mwlfo_core
// Tick input register, divider count, wave state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwlfo_core #(
	parameter int SINE_STEPS     = mwlfo_pkg::SINE_STEPS_DEF,
	parameter int SINE_FRAC_BITS = mwlfo_pkg::SINE_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mwlfo_pkg::cfg_t                   cfg,
	input  wire logic [mwlfo_pkg::PERIOD_W-1:0]    interval,
	input  wire logic                              busy,
	input  wire logic [SINE_FRAC_BITS-1:0]         frac,
	output logic      [$clog2(SINE_STEPS)-1:0]     rom_addr,
	mwlfo_tick_if.sink                             tick_ch,
	mwlfo_level_if.source                          level_ch
);
	import mwlfo_pkg::*;

	localparam int SIDX_W = $clog2(SINE_STEPS);
	localparam int PROD_W = SINE_FRAC_BITS + LEVEL_W + 1;

	logic                       valid_s1;
	logic                       tick_s1;
	logic                       out_valid_q;
	logic [LEVEL_W-1:0]         level_q;
	logic                       restart_q;

	logic [PERIOD_W-1:0]        elapsed_q;
	logic [SIDX_W-1:0]          sine_idx_q;
	logic [LEVEL_W-1:0]         sine_level_q;
	logic signed [LEVEL_W:0]    tri_level_q;
	logic                       tri_rising_q;
	logic                       tri_armed_q;
	logic [LEVEL_W-1:0]         up_level_q;
	logic [LEVEL_W-1:0]         down_level_q;
	logic                       square_high_q;

	logic [PERIOD_W-1:0]        elapsed_d;
	logic [PERIOD_W-1:0]        ec_inc;
	logic                       step;
	logic [SIDX_W-1:0]          sine_idx_d;
	logic [LEVEL_W-1:0]         sine_level_d;
	logic signed [LEVEL_W:0]    tri_level_d;
	logic                       tri_rising_d;
	logic                       tri_armed_d;
	logic [LEVEL_W-1:0]         up_level_d;
	logic [LEVEL_W-1:0]         down_level_d;
	logic                       square_high_d;
	logic [LEVEL_W-1:0]         level_d;
	logic                       restart_d;

	logic [LEVEL_W-1:0]         lo;
	logic [LEVEL_W-1:0]         hi;
	logic [LEVEL_W-1:0]         rng;
	logic signed [LEVEL_W:0]    lo_s;
	logic signed [LEVEL_W:0]    hi_s;
	logic [PROD_W-1:0]          prod;
	logic [LEVEL_W-1:0]         sine_p;
	logic [SIDX_W:0]            idx_w;
	logic [LEVEL_W:0]           up_w;
	logic signed [LEVEL_W:0]    down_w;

	logic en;
	logic proc;
	logic in_acc;

	assign en             = !out_valid_q || level_ch.ready;
	assign proc           = valid_s1 && en;
	assign tick_ch.ready  = !busy && (!valid_s1 || en);
	assign in_acc         = tick_ch.valid && tick_ch.ready;

	always_comb begin
		ec_inc = elapsed_q;
		step   = 1'b0;
		if (tick_s1) begin
			if (elapsed_q != '1) ec_inc = elapsed_q + 1'b1;
			if (ec_inc >= interval) step = 1'b1;
		end
		elapsed_d = step ? '0 : ec_inc;
	end

	always_comb begin
		lo     = cfg.level_min;
		hi     = (cfg.level_max < cfg.level_min) ? cfg.level_min : cfg.level_max;
		rng    = hi - lo;
		lo_s   = signed'({1'b0, lo});
		hi_s   = signed'({1'b0, hi});
		prod   = PROD_W'(frac) * PROD_W'(rng) + (PROD_W'(1) << (SINE_FRAC_BITS - 1));
		sine_p = prod[SINE_FRAC_BITS +: LEVEL_W];
	end

	always_comb begin
		sine_idx_d    = sine_idx_q;
		sine_level_d  = sine_level_q;
		tri_level_d   = tri_level_q;
		tri_rising_d  = tri_rising_q;
		tri_armed_d   = tri_armed_q;
		up_level_d    = up_level_q;
		down_level_d  = down_level_q;
		square_high_d = square_high_q;
		level_d       = '0;
		restart_d     = 1'b0;
		idx_w         = {1'b0, sine_idx_q};
		up_w          = {1'b0, up_level_q};
		down_w        = signed'({1'b0, down_level_q});
		case (wave_t'(cfg.waveform))
			WAVE_SINE: begin
				if (step) begin
					sine_level_d = lo + sine_p;
					idx_w        = {1'b0, sine_idx_q} + 1'b1;
				end
				if (idx_w >= (SIDX_W + 1)'(SINE_STEPS)) begin
					sine_idx_d = '0;
					restart_d  = 1'b1;
				end else begin
					sine_idx_d = idx_w[SIDX_W-1:0];
				end
				level_d = sine_level_d;
			end
			WAVE_TRIANGLE: begin
				if (step) begin
					tri_level_d = tri_rising_q ? tri_level_q + 9'sd1 : tri_level_q - 9'sd1;
				end
				if (tri_level_d >= hi_s) begin
					tri_rising_d = 1'b0;
					tri_armed_d  = 1'b1;
				end else if ((tri_level_d <= lo_s) && tri_armed_q) begin
					tri_rising_d = 1'b1;
					tri_armed_d  = 1'b0;
					restart_d    = 1'b1;
				end
				level_d = tri_level_d[LEVEL_W] ? '0 : tri_level_d[LEVEL_W-1:0];
			end
			WAVE_RAMP_UP: begin
				if (step) up_w = {1'b0, up_level_q} + 1'b1;
				if (up_w >= {1'b0, hi}) begin
					up_level_d = lo;
					restart_d  = 1'b1;
				end else begin
					up_level_d = up_w[LEVEL_W-1:0];
				end
				level_d = up_level_d;
			end
			WAVE_RAMP_DOWN: begin
				if (step) down_w = signed'({1'b0, down_level_q}) - 9'sd1;
				if (down_w <= lo_s) begin
					down_level_d = hi;
					restart_d    = 1'b1;
				end else begin
					down_level_d = down_w[LEVEL_W-1:0];
				end
				level_d = down_level_d;
			end
			WAVE_SQUARE: begin
				if (step) begin
					square_high_d = !square_high_q;
					restart_d     = !square_high_q;
				end
				level_d = square_high_d ? hi : lo;
			end
			default: begin
				level_d   = '0;
				restart_d = 1'b0;
			end
		endcase
	end

	assign rom_addr = proc ? sine_idx_d : sine_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			elapsed_q     <= '0;
			sine_idx_q    <= '0;
			sine_level_q  <= '0;
			tri_level_q   <= '0;
			tri_rising_q  <= 1'b1;
			tri_armed_q   <= 1'b1;
			up_level_q    <= '0;
			down_level_q  <= '0;
			square_high_q <= 1'b0;
		end else begin
			if (in_acc) valid_s1 <= 1'b1;
			else if (en) valid_s1 <= 1'b0;
			if (en) out_valid_q <= valid_s1;
			if (proc) begin
				elapsed_q     <= elapsed_d;
				sine_idx_q    <= sine_idx_d;
				sine_level_q  <= sine_level_d;
				tri_level_q   <= tri_level_d;
				tri_rising_q  <= tri_rising_d;
				tri_armed_q   <= tri_armed_d;
				up_level_q    <= up_level_d;
				down_level_q  <= down_level_d;
				square_high_q <= square_high_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) tick_s1 <= tick_ch.tick;
		if (proc) begin
			level_q   <= level_d;
			restart_q <= restart_d;
		end
	end

	assign level_ch.valid         = out_valid_q;
	assign level_ch.level         = level_q;
	assign level_ch.phase_restart = restart_q;

	a_sine_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, sine_idx_q} < (SIDX_W + 1)'(SINE_STEPS))
		else $error("sine index left the table");

	a_falling_armed: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_rising_q |-> tri_armed_q)
		else $error("triangle falling without re-arm flag");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en) |=> (valid_s1 && $stable(tick_s1)))
		else $error("input stage lost a transaction while stalled");

	a_tri_floor: assert property (@(posedge clk) disable iff (!arst_n)
		tri_level_q >= -9'sd1)
		else $error("triangle level below its floor");

endmodule

`default_nettype wire

[rtl/core/multi_waveform_lfo_unit.sv]
// ----------------------------------------------------------------------------
// multi_waveform_lfo_unit
// Multi-waveform LFO for LED drive: APB configuration, interval divider,
// sine table and per-tick wave update.
// ----------------------------------------------------------------------------
// A tick is registered in the input stage and then in the result register.
// Throughput: one tick per cycle when the divider is idle and nothing stalls.
// Reset and every register write start a serial interval division
// (one quotient bit per cycle); tick_ch.ready stays low until it is done.
// Reset is asynchronous and active low and restores the register defaults.
`default_nettype none

module multi_waveform_lfo_unit #(
	parameter int SINE_STEPS     = mwlfo_pkg::SINE_STEPS_DEF,
	parameter int SINE_FRAC_BITS = mwlfo_pkg::SINE_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mwlfo_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mwlfo_pkg::DATA_W-1:0]  pwdata,
	output logic      [mwlfo_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	mwlfo_tick_if.sink                         tick_ch,
	mwlfo_level_if.source                      level_ch
);
	import mwlfo_pkg::*;

	cfg_t                          cfg;
	logic                          start;
	logic                          busy;
	logic [PERIOD_W-1:0]           interval;
	logic [$clog2(SINE_STEPS)-1:0] rom_addr;
	logic [SINE_FRAC_BITS-1:0]     frac;

	mwlfo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.start   (start)
	);

	mwlfo_div #(
		.SINE_STEPS (SINE_STEPS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg      (cfg),
		.interval (interval),
		.busy     (busy)
	);

	mwlfo_sine_rom #(
		.SINE_STEPS     (SINE_STEPS),
		.SINE_FRAC_BITS (SINE_FRAC_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (frac)
	);

	mwlfo_core #(
		.SINE_STEPS     (SINE_STEPS),
		.SINE_FRAC_BITS (SINE_FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.interval (interval),
		.busy     (busy),
		.frac     (frac),
		.rom_addr (rom_addr),
		.tick_ch  (tick_ch),
		.level_ch (level_ch)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for multi_waveform_lfo_unit. A short directed table
// and then randomized configuration phases feed microsecond ticks through
// the valid/ready channels. Both sides idle at random, and the receiver holds
// off once for a long stretch. Each level transaction is checked against its
// table row or an in-bench model of the interval divider and five waveforms.
// ----------------------------------------------------------------------------
module tb;
	import mwlfo_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TABLE_STEPS = 314;
	localparam int FRAC_BITS   = 16;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 300;

	localparam logic [WAVE_W-1:0] WAVE_SPARE_5 = 3'd5;
	localparam logic [WAVE_W-1:0] WAVE_SPARE_7 = 3'd7;

	localparam longint unsigned FX_ONE     = 64'd1073741824;
	localparam longint unsigned FX_PI      = 64'd3373259426;
	localparam longint unsigned FX_HALF_PI = 64'd1686629713;
	localparam longint unsigned FX_TWO_PI  = 64'd6746518852;
	localparam longint unsigned RAD_SCALE  = 64'd50;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               phase_restart;
	} lfo_out_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] value;
		logic        typed;
		lfo_out_t    want;
	} plan_row_t;

	localparam int PLAN_LEN = 36;
	localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
		'{ROW_TICK, REG_WAVEFORM,  32'd0,             1'b1, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_SQUARE),  1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_PERIOD,    32'd0,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd255, 1'b1}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd0,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_LEVEL_MIN, 32'd200,           1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_LEVEL_MAX, 32'd100,           1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd200, 1'b1}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd200, 1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_SPARE_5), 1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_SPARE_7), 1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd0,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_LEVEL_MIN, 32'd0,             1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_LEVEL_MAX, 32'd255,           1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_PERIOD,    32'hFFFF_FFFF,     1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_RAMP_UP), 1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_RAMP_DOWN), 1'b0, '{8'd0, 1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd0,             1'b1, '{8'd255, 1'b1}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd255, 1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_TRIANGLE), 1'b0, '{8'd0,  1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd0,             1'b1, '{8'd0,   1'b1}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b1, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_PERIOD,    32'd0,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_LEVEL_MAX, 32'd2,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_REG,  REG_WAVEFORM,  32'(WAVE_SINE),    1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}},
		'{ROW_TICK, REG_WAVEFORM,  32'd1,             1'b0, '{8'd0,   1'b0}}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	mwlfo_tick_if  tick_ch();
	mwlfo_level_if level_ch();

	multi_waveform_lfo_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tick_ch  (tick_ch),
		.level_ch (level_ch)
	);

	// Model of the block: configuration, divider and wave state.
	logic [WAVE_W-1:0]  cfg_wave;
	logic [LEVEL_W-1:0] cfg_min;
	logic [LEVEL_W-1:0] cfg_max;
	logic [31:0]        cfg_period;
	logic [31:0]        elapsed;
	logic [31:0]        interval;
	int                 sine_pos;
	int                 sine_out;
	int                 tri_out;
	int                 up_out;
	int                 down_out;
	bit                 tri_up;
	bit                 tri_rearm;
	bit                 square_on;
	longint unsigned    sine_table [TABLE_STEPS];

	lfo_out_t pending_levels [$];
	int       mismatch_count;
	int       levels_seen;
	int       cycle_count;
	int       send_gap_pct;
	int       sink_gap_pct;

	function automatic longint unsigned sine_fraction(input int unsigned i);
		longint unsigned ang;
		longint unsigned sq;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned mag;
		longint unsigned v;
		longint unsigned f;
		longint unsigned fmax;
		longint unsigned den;
		bit below;
		ang = i;
		ang = ((ang << 30) + RAD_SCALE / 2) / RAD_SCALE;
		ang = ang % FX_TWO_PI;
		below = 1'b0;
		if (ang >= FX_PI) begin
			ang = ang - FX_PI;
			below = 1'b1;
		end
		if (ang > FX_HALF_PI) ang = FX_PI - ang;
		sq = (ang * ang) >> 30;
		term = ang;
		pos = ang;
		neg = 0;
		for (int n = 1; n <= 7; n++) begin
			den = (2 * n) * (2 * n + 1);
			term = ((term * sq) >> 30) / den;
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		mag = (pos > neg) ? pos - neg : 0;
		if (mag > FX_ONE) mag = FX_ONE;
		v = below ? (FX_ONE / 2) - mag / 2 : (FX_ONE / 2) + mag / 2;
		f = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		fmax = (64'd1 << FRAC_BITS) - 1;
		return (f > fmax) ? fmax : f;
	endfunction

	function automatic int upper_limit();
		return (cfg_max < cfg_min) ? int'(cfg_min) : int'(cfg_max);
	endfunction

	function automatic logic [31:0] reg_mask(input reg_idx_t idx);
		case (idx)
		REG_WAVEFORM: return 32'h0000_0007;
		REG_LEVEL_MIN, REG_LEVEL_MAX: return 32'h0000_00FF;
		default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic recompute_interval();
		int unsigned     span;
		longint unsigned wide;
		span = upper_limit() - int'(cfg_min);
		if (span == 0) span = 1;
		case (cfg_wave)
		WAVE_SINE: interval = cfg_period / TABLE_STEPS;
		WAVE_TRIANGLE: interval = cfg_period / (2 * span);
		WAVE_RAMP_UP, WAVE_RAMP_DOWN: begin
			wide = cfg_period / span;
			wide = wide * 2;
			interval = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
		end
		default: interval = cfg_period;
		endcase
	endtask

	task automatic lfo_advance(input logic t, output lfo_out_t r);
		bit              stepped;
		bit              restart;
		int              lo;
		int              hi;
		int              lvl;
		longint unsigned prod;
		stepped = 1'b0;
		restart = 1'b0;
		lo = int'(cfg_min);
		hi = upper_limit();
		lvl = 0;
		if (t) begin
			if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 1;
			if (elapsed >= interval) begin
				stepped = 1'b1;
				elapsed = '0;
			end
		end
		case (cfg_wave)
		WAVE_SINE: begin
			if (stepped) begin
				if (sine_pos >= TABLE_STEPS) sine_pos = 0;
				prod = sine_table[sine_pos];
				prod = prod * (hi - lo);
				prod = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				sine_out = lo + int'(prod);
				sine_pos = sine_pos + 1;
			end
			if (sine_pos >= TABLE_STEPS) begin
				sine_pos = 0;
				restart = 1'b1;
			end
			lvl = sine_out;
		end
		WAVE_TRIANGLE: begin
			if (stepped) tri_out = tri_out + (tri_up ? 1 : -1);
			if (tri_out >= hi) begin
				tri_up = 1'b0;
				tri_rearm = 1'b1;
			end else if (tri_out <= lo && tri_rearm) begin
				tri_up = 1'b1;
				tri_rearm = 1'b0;
				restart = 1'b1;
			end
			lvl = tri_out;
		end
		WAVE_RAMP_UP: begin
			if (stepped) up_out = up_out + 1;
			if (up_out >= hi) begin
				up_out = lo;
				restart = 1'b1;
			end
			lvl = up_out;
		end
		WAVE_RAMP_DOWN: begin
			if (stepped) down_out = down_out - 1;
			if (down_out <= lo) begin
				down_out = hi;
				restart = 1'b1;
			end
			lvl = down_out;
		end
		WAVE_SQUARE: begin
			if (stepped) begin
				square_on = !square_on;
				if (square_on) restart = 1'b1;
			end
			lvl = square_on ? hi : lo;
		end
		default: lvl = 0;
		endcase
		if (lvl < 0) lvl = 0;
		if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
		r.level = lvl[LEVEL_W-1:0];
		r.phase_restart = restart;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Called at a falling edge; returns at a falling edge with valid still high.
	task automatic send_tick(input logic t, input bit typed, input lfo_out_t want);
		lfo_out_t predicted;
		if ($urandom_range(1, 100) <= send_gap_pct) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.tick <= t;
		do @(posedge clk); while (!tick_ch.ready);
		lfo_advance(t, predicted);
		pending_levels.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_levels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = reg_mask(idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (val & mask)) report_mismatch("register readback", prdata, val & mask);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_WAVEFORM: cfg_wave = val[WAVE_W-1:0];
		REG_LEVEL_MIN: cfg_min = val[LEVEL_W-1:0];
		REG_LEVEL_MAX: cfg_max = val[LEVEL_W-1:0];
		default: cfg_period = val;
		endcase
		recompute_interval();
		@(negedge clk);
	endtask

	task automatic random_config();
		logic [31:0]        per;
		logic [LEVEL_W-1:0] lo_v;
		logic [LEVEL_W-1:0] hi_v;
		logic [31:0]        wave;
		case ($urandom_range(0, 5))
		0: per = '0;
		1: per = $urandom_range(1, 40);
		2: per = 32'hFFFF_FFFF;
		3: per = $urandom;
		default: per = $urandom_range(41, 2000);
		endcase
		case ($urandom_range(0, 3))
		0: begin
			lo_v = '0;
			hi_v = '1;
		end
		1: begin
			lo_v = LEVEL_W'($urandom);
			hi_v = LEVEL_W'($urandom);
		end
		2: begin
			lo_v = LEVEL_W'($urandom);
			hi_v = lo_v;
		end
		default: begin
			lo_v = LEVEL_W'($urandom_range(0, 100));
			hi_v = LEVEL_W'($urandom_range(150, 255));
		end
		endcase
		if ($urandom_range(0, 7) != 0) wave = $urandom_range(WAVE_SINE, WAVE_SQUARE);
		else wave = $urandom_range(WAVE_SPARE_5, WAVE_SPARE_7);
		settle();
		write_reg(REG_WAVEFORM, wave);
		write_reg(REG_LEVEL_MIN, 32'(lo_v));
		write_reg(REG_LEVEL_MAX, 32'(hi_v));
		write_reg(REG_PERIOD, per);
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multi_waveform_lfo_unit test failed");
			$finish;
		end
	end

	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		level_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && levels_seen >= HOLD_AT) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && $urandom_range(1, 100) <= sink_gap_pct) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				level_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				level_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		lfo_out_t want;
		if (arst_n && level_ch.valid && level_ch.ready) begin
			levels_seen++;
			if (pending_levels.size() == 0) begin
				report_mismatch("level transaction with none pending", level_ch.level, 0);
			end else begin
				want = pending_levels.pop_front();
				if (level_ch.level !== want.level)
					report_mismatch("level", level_ch.level, want.level);
				if (level_ch.phase_restart !== want.phase_restart)
					report_mismatch("phase_restart", level_ch.phase_restart, want.phase_restart);
			end
		end
	end

	initial begin
		int n_items;
		mismatch_count = 0;
		levels_seen = 0;
		cycle_count = 0;
		send_gap_pct = 20;
		sink_gap_pct = 10;
		for (int i = 0; i < TABLE_STEPS; i++) sine_table[i] = sine_fraction(i);
		cfg_wave = WAVEFORM_RST;
		cfg_min = LEVEL_MIN_RST;
		cfg_max = LEVEL_MAX_RST;
		cfg_period = PERIOD_RST;
		elapsed = '0;
		sine_pos = 0;
		sine_out = 0;
		tri_out = 0;
		up_out = 0;
		down_out = 0;
		tri_up = 1'b1;
		tri_rearm = 1'b1;
		square_on = 1'b0;
		recompute_interval();

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.tick = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_REG) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].value);
			end else begin
				send_tick(PLAN[i].value[0], PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < 11; ph++) begin
			case ($urandom_range(0, 2))
			0: send_gap_pct = 0;
			1: send_gap_pct = 10;
			default: send_gap_pct = 25;
			endcase
			case ($urandom_range(0, 2))
			0: sink_gap_pct = 0;
			1: sink_gap_pct = 5;
			default: sink_gap_pct = 15;
			endcase
			random_config();
			if (ph == 5) begin
				// A full sine cycle at one step per tick, with the receiver hold-off.
				send_gap_pct = 0;
				write_reg(REG_WAVEFORM, 32'(WAVE_SINE));
				write_reg(REG_PERIOD, $urandom_range(0, TABLE_STEPS - 1));
				repeat (320) send_tick(1'b1, 1'b0, '0);
			end else begin
				if (ph == 10) begin
					send_gap_pct = 0;
					sink_gap_pct = 0;
				end
				n_items = $urandom_range(30, 40);
				repeat (n_items) send_tick($urandom_range(1, 100) <= 85, 1'b0, '0);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("multi_waveform_lfo_unit test passed");
		end else begin
			$display("multi_waveform_lfo_unit test failed");
		end
		$finish;
	end

endmodule
